### design/hvd_pkg.sv
`timescale 1ns / 1ps
package hvd_pkg;

	localparam int CORDIC_ITER_DEF = 24;
	localparam int SQRT_STEPS      = 31;
	localparam int XW              = 34;

	typedef logic signed [XW-1:0] cval_t;

	// One CORDIC vector plus a one-bit tag that rides along the chain.
	typedef struct packed {
		cval_t x;
		cval_t y;
		cval_t z;
		logic  tag;
	} cordic_t;

	// Partial remainder and root of the restoring square root.
	typedef struct packed {
		logic [61:0] rem;
		logic [61:0] root;
	} sqrt_t;

	localparam logic [31:0] DIV_FULL = 32'd1800000000;
	localparam logic [31:0] DIV_HALF = 32'd3600000000;

	// Reciprocals scaled by 2^65, rounded to nearest.
	localparam logic [95:0] RECIP_FULL_W = ((96'd1 << 65) + 96'd900000000) / 96'd1800000000;
	localparam logic [95:0] RECIP_HALF_W = ((96'd1 << 65) + 96'd1800000000) / 96'd3600000000;
	localparam logic [34:0] RECIP_FULL   = RECIP_FULL_W[34:0];
	localparam logic [34:0] RECIP_HALF   = RECIP_HALF_W[34:0];

	localparam cval_t CORDIC_GAIN = 34'sd652032874;
	localparam cval_t Q30_ONE     = 34'sd1073741824;
	localparam cval_t HALF_TURN   = 34'sd2147483648;

	localparam logic [22:0] RADIUS_RESET = 23'd6371000;
	localparam logic [37:0] MM_K         = 38'd210828714133;
	localparam logic [63:0] M_RESET_W    =
		((64'd6371000 * 64'd210828714133) + (64'd1 << 31)) >> 32;
	localparam logic [28:0] M_RESET      = M_RESET_W[28:0];
	localparam logic [34:0] DIST_MAX     = 35'd22000000000;

	// atan(2^-i) in units of 2^-32 turn.
	localparam logic [29:0] ATAN_TAB [32] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
		30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
		30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
		30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
	};

endpackage

### design/hvd_pos_if.sv
`timescale 1ns / 1ps
interface hvd_pos_if;
	logic               valid;
	logic               ready;
	logic signed [30:0] lat_a;
	logic signed [31:0] lon_a;
	logic signed [30:0] lat_b;
	logic signed [31:0] lon_b;

	modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
	modport sink (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

### design/hvd_dist_if.sv
`timescale 1ns / 1ps
interface hvd_dist_if;
	logic        valid;
	logic        ready;
	logic [34:0] distance_mm;

	modport source (output valid, distance_mm, input ready);
	modport sink (input valid, distance_mm, output ready);
endinterface

### design/hvd_turn.sv
`timescale 1ns / 1ps
module hvd_turn (
	input  logic               clk,
	input  logic               en,
	input  logic               half,
	input  logic signed [32:0] v,
	output logic [31:0]        q
);
	import hvd_pkg::*;

	logic [32:0]        mag;
	logic [67:0]        p_s1;
	logic [32:0]        mag_s1, mag_s2, mag_s3;
	logic               neg_s1, neg_s2, neg_s3;
	logic               half_s1, half_s2, half_s3;
	logic [68:0]        p_rnd;
	logic [34:0]        q_s2, q_s3;
	logic [66:0]        prod_s3;
	logic [31:0]        dv;
	logic [64:0]        num;
	logic signed [68:0] r;
	logic [34:0]        qc;
	logic [31:0]        q_s4;

	assign mag = v[32] ? 33'(-v) : 33'(v);

	// Reciprocal estimate, within one of the rounded quotient.
	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= 68'(mag) * 68'(half ? RECIP_HALF : RECIP_FULL);
			mag_s1  <= mag;
			neg_s1  <= v[32];
			half_s1 <= half;
		end
	end

	assign p_rnd = 69'(p_s1) + (69'd1 << 33);

	always_ff @(posedge clk) begin
		if (en) begin
			q_s2    <= p_rnd[68:34];
			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			half_s2 <= half_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= 67'(q_s2) * 67'(half_s2 ? DIV_HALF : DIV_FULL);
			q_s3    <= q_s2;
			mag_s3  <= mag_s2;
			neg_s3  <= neg_s2;
			half_s3 <= half_s2;
		end
	end

	// Remainder check corrects the estimate by one either way.
	always_comb begin
		dv  = half_s3 ? DIV_HALF : DIV_FULL;
		num = {1'b0, mag_s3, 31'b0} + 65'(dv >> 1);
		r   = $signed({4'b0, num}) - $signed({2'b0, prod_s3});
		if (r[68]) begin
			qc = q_s3 - 35'd1;
		end else if (r >= $signed({37'b0, dv})) begin
			qc = q_s3 + 35'd1;
		end else begin
			qc = q_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s4 <= neg_s3 ? (32'd0 - qc[31:0]) : qc[31:0];
		end
	end

	assign q = q_s4;
endmodule

### design/hvd_cordic_cell.sv
`timescale 1ns / 1ps
module hvd_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic            clk,
	input  logic            en,
	input  logic            vect,
	input  hvd_pkg::cordic_t d_in,
	output hvd_pkg::cordic_t d_out
);
	import hvd_pkg::*;

	cval_t   dx, dy, at;
	logic    neg;
	cordic_t nxt, d_q;

	// Rotation steers on the residual angle, vectoring on the sign of y.
	always_comb begin
		dx      = d_in.y >>> STAGE;
		dy      = d_in.x >>> STAGE;
		at      = cval_t'(ATAN_TAB[STAGE]);
		neg     = vect ? !d_in.y[XW-1] : d_in.z[XW-1];
		nxt.tag = d_in.tag;
		if (!neg) begin
			nxt.x = d_in.x - dx;
			nxt.y = d_in.y + dy;
			nxt.z = d_in.z - at;
		end else begin
			nxt.x = d_in.x + dx;
			nxt.y = d_in.y - dy;
			nxt.z = d_in.z + at;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign d_out = d_q;
endmodule

### design/hvd_sqrt_cell.sv
`timescale 1ns / 1ps
module hvd_sqrt_cell #(
	parameter int SHIFT = 60
) (
	input  logic          clk,
	input  logic          en,
	input  hvd_pkg::sqrt_t d_in,
	output hvd_pkg::sqrt_t d_out
);
	import hvd_pkg::*;

	logic [61:0] bitv, trial;
	sqrt_t       nxt, d_q;

	always_comb begin
		bitv  = 62'd1 << SHIFT;
		trial = d_in.root + bitv;
		if (d_in.rem >= trial) begin
			nxt.rem  = d_in.rem - trial;
			nxt.root = (d_in.root >> 1) + bitv;
		end else begin
			nxt.rem  = d_in.rem;
			nxt.root = d_in.root >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign d_out = d_q;
endmodule

### design/haversine_distance_core.sv
`timescale 1ns / 1ps
// Channel   Dir  Payload                          Request taken when
// pos       in   lat_a, lon_a, lat_b, lon_b       pos.valid && pos.ready
// distance  out  distance_mm                      distance.valid && distance.ready
// cfg       in   cfg_wdata (earth_radius_m)       cfg_we
//
// One request enters per cycle unless the output stalls; each result passes
// through the CORDIC cell chains and the 31-step square root chain. Reset
// clears the valid line and loads the default radius. A stalled output
// freezes the whole pipeline; ready stays high whenever the output register
// is empty or being taken.
module haversine_distance_core #(
	parameter int CORDIC_ITERATIONS = hvd_pkg::CORDIC_ITER_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	hvd_pos_if.sink     pos,
	hvd_dist_if.source  distance,
	input  logic        cfg_we,
	input  logic [22:0] cfg_wdata
);
	import hvd_pkg::*;

	localparam int N   = CORDIC_ITERATIONS;
	localparam int LAT = 2 * N + SQRT_STEPS + 11;

	// The whole pipeline moves as one; a full output register that is not
	// being taken holds every stage.
	logic           adv;
	logic [LAT-1:0] vld_q;

	assign adv       = !vld_q[LAT-1] || distance.ready;
	assign pos.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], pos.valid};
		end
	end

	// Radius register and its millimetre scale, M = R*K/2^32 rounded. The user
	// changes configuration only while idle; the block does not enforce it.
	logic [22:0] radius_q;
	logic [28:0] m_q;
	logic [61:0] m_full;

	assign m_full = 62'(radius_q) * 62'(MM_K) + (62'd1 << 31);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			m_q      <= M_RESET;
		end else begin
			if (cfg_we) begin
				radius_q <= cfg_wdata;
			end
			m_q <= m_full[60:32];
		end
	end

	// Input stage: exact coordinate differences are taken before conversion.
	logic signed [32:0] ang_s0 [4];

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s0[0] <= 33'(pos.lat_b) - 33'(pos.lat_a);
			ang_s0[1] <= 33'(pos.lon_b) - 33'(pos.lon_a);
			ang_s0[2] <= 33'(pos.lat_a);
			ang_s0[3] <= 33'(pos.lat_b);
		end
	end

	// Conversion to fractions of a turn; the differences become half angles.
	logic [31:0] turn [4];

	generate
		for (genvar c = 0; c < 4; c++) begin : g_turn
			hvd_turn u_turn (
				.clk  (clk),
				.en   (adv),
				.half (c < 2),
				.v    (ang_s0[c]),
				.q    (turn[c])
			);
		end
	endgenerate

	// Fold the angle into [-90, 90] degrees; the tag remembers to negate the
	// sine and cosine at the end of the chain.
	function automatic cordic_t fold_start(input logic [31:0] ang);
		cval_t   z;
		cordic_t r;
		z     = cval_t'($signed(ang));
		r.x   = CORDIC_GAIN;
		r.y   = '0;
		r.z   = z;
		r.tag = 1'b0;
		if (z > Q30_ONE) begin
			r.z   = z - HALF_TURN;
			r.tag = 1'b1;
		end else if (z < -Q30_ONE) begin
			r.z   = z + HALF_TURN;
			r.tag = 1'b1;
		end
		return r;
	endfunction

	// Four rotation chains: half dlat, half dlon, lat_a, lat_b.
	cordic_t sc [4][N+1];

	generate
		for (genvar c = 0; c < 4; c++) begin : g_sc
			assign sc[c][0] = fold_start(turn[c]);
			for (genvar i = 0; i < N; i++) begin : g_cell
				hvd_cordic_cell #(.STAGE(i)) u_cell (
					.clk   (clk),
					.en    (adv),
					.vect  (1'b0),
					.d_in  (sc[c][i]),
					.d_out (sc[c][i+1])
				);
			end
		end
	endgenerate

	// Products of the haversine term, one multiplier level per stage.
	cval_t              sh_lat_s1, sh_lon_s1, c1_s1, c2_s1;
	logic signed [67:0] m_lat, m_lon, m_cc;
	logic signed [35:0] sq_lat_s2, sq_lon_s2, cc_s2, sq_lat_s3;
	logic signed [71:0] m_t;
	logic signed [36:0] t_s3;
	logic signed [37:0] a_sum;
	logic [30:0]        a_s4, b_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			sh_lat_s1 <= sc[0][N].tag ? -sc[0][N].y : sc[0][N].y;
			sh_lon_s1 <= sc[1][N].tag ? -sc[1][N].y : sc[1][N].y;
			c1_s1     <= sc[2][N].tag ? -sc[2][N].x : sc[2][N].x;
			c2_s1     <= sc[3][N].tag ? -sc[3][N].x : sc[3][N].x;
		end
	end

	assign m_lat = sh_lat_s1 * sh_lat_s1;
	assign m_lon = sh_lon_s1 * sh_lon_s1;
	assign m_cc  = c1_s1 * c2_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_lat_s2 <= m_lat[65:30];
			sq_lon_s2 <= m_lon[65:30];
			cc_s2     <= m_cc[65:30];
		end
	end

	assign m_t = cc_s2 * sq_lon_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s3      <= m_t[66:30];
			sq_lat_s3 <= sq_lat_s2;
		end
	end

	// Clamp a into [0, 1] before the roots.
	assign a_sum = 38'(sq_lat_s3) + 38'(t_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (a_sum < 0) begin
				a_s4 <= '0;
				b_s4 <= Q30_ONE[30:0];
			end else if (a_sum > 38'(Q30_ONE)) begin
				a_s4 <= Q30_ONE[30:0];
				b_s4 <= '0;
			end else begin
				a_s4 <= a_sum[30:0];
				b_s4 <= Q30_ONE[30:0] - a_sum[30:0];
			end
		end
	end

	// Two restoring square roots, one result bit per cell.
	sqrt_t sa [SQRT_STEPS+1];
	sqrt_t sb [SQRT_STEPS+1];

	assign sa[0] = '{rem: {1'b0, a_s4, 30'b0}, root: '0};
	assign sb[0] = '{rem: {1'b0, b_s4, 30'b0}, root: '0};

	generate
		for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
			hvd_sqrt_cell #(.SHIFT(2 * (SQRT_STEPS - 1 - j))) u_sqa (
				.clk   (clk),
				.en    (adv),
				.d_in  (sa[j]),
				.d_out (sa[j+1])
			);
			hvd_sqrt_cell #(.SHIFT(2 * (SQRT_STEPS - 1 - j))) u_sqb (
				.clk   (clk),
				.en    (adv),
				.d_in  (sb[j]),
				.d_out (sb[j+1])
			);
		end
	endgenerate

	// Vectoring chain for atan2(sqrt(a), sqrt(1 - a)); the tag marks a zero
	// root, which forces a zero central angle.
	logic [30:0] ra, rb;
	cordic_t     at [N+1];

	assign ra = sa[SQRT_STEPS].root[30:0];
	assign rb = sb[SQRT_STEPS].root[30:0];
	assign at[0] = '{x: cval_t'(rb), y: cval_t'(ra), z: '0, tag: (ra == '0)};

	generate
		for (genvar i = 0; i < N; i++) begin : g_atan
			hvd_cordic_cell #(.STAGE(i)) u_cell (
				.clk   (clk),
				.en    (adv),
				.vect  (1'b1),
				.d_in  (at[i]),
				.d_out (at[i+1])
			);
		end
	endgenerate

	// Scale the angle into millimetres and saturate.
	logic [30:0] z_ang;
	logic [59:0] prod_s5;
	logic [60:0] d_rnd;
	logic [34:0] dist_q;

	assign z_ang = (at[N].tag || at[N].z[XW-1]) ? '0 : at[N].z[30:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s5 <= 60'(z_ang) * 60'(m_q);
		end
	end

	assign d_rnd = 61'(prod_s5) + (61'd1 << 23);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (d_rnd[60:24] > 37'(DIST_MAX)) begin
				dist_q <= DIST_MAX;
			end else begin
				dist_q <= d_rnd[58:24];
			end
		end
	end

	assign distance.valid       = vld_q[LAT-1];
	assign distance.distance_mm = dist_q;

`ifndef SYNTHESIS
	a_dist_bound: assert property (@(posedge clk) disable iff (!arst_n)
		distance.valid |-> distance.distance_mm <= DIST_MAX)
		else $error("distance above saturation bound");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[LAT-1] |-> pos.ready)
		else $error("input held off with an empty output register");

	// The clamp stage holds a live request when its valid bit is set.
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[N+8] |-> (32'(a_s4) + 32'(b_s4)) == 32'(Q30_ONE))
		else $error("clamped a and 1 - a do not sum to one");
`endif
endmodule
